// ===== rtl/lsr_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD status register block package
// Shared command codes, register offsets, the decoded item record and
// a palette shade helper used by the front decoder, the queue and the back end.
// ----------------------------------------------------------------------------
package lsr_pkg;

  // Input stream payload widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  // Result stream payload width (42 bits of fields, padded to whole bytes)
  localparam int unsigned OutDataW = 48;

  // Line timing
  localparam logic [7:0] LinesPerFrame     = 8'd154;
  localparam logic [6:0] LineIrqEnableMask = 7'd64;

  // Reset values
  localparam logic [7:0] ControlReset = 8'h91;
  localparam logic [7:0] BgPalReset   = 8'hFC;
  localparam logic [7:0] ObjPalReset  = 8'hFF;

  // Write masks
  localparam logic [6:0] StatusKeepMask  = 7'b0000111;
  localparam logic [6:0] StatusWriteMask = 7'b1111000;
  localparam logic [7:0] ObjPalWriteMask = 8'b11111100;
  localparam logic [6:0] CoincClearMask  = 7'b1111011;
  localparam logic [6:0] CoincSetMask    = 7'b0000100;
  localparam logic [6:0] ModeClearMask   = 7'b1111100;

  // Object heights
  localparam logic [4:0] ObjHeightTall  = 5'd16;
  localparam logic [4:0] ObjHeightShort = 5'd8;

  // Commands carried in tuser
  typedef enum logic [1:0] {
    OpRead    = 2'd0,
    OpWrite   = 2'd1,
    OpAdvance = 2'd2,
    OpMode    = 2'd3
  } op_e;

  // Register offsets from the block base
  typedef enum logic [3:0] {
    RegControl = 4'd0,
    RegStatus  = 4'd1,
    RegScrollY = 4'd2,
    RegScrollX = 4'd3,
    RegLine    = 4'd4,
    RegCompare = 4'd5,
    RegBgPal   = 4'd7,
    RegObjPal0 = 4'd8,
    RegObjPal1 = 4'd9,
    RegWindowY = 4'd10,
    RegWindowX = 4'd11
  } reg_e;

  // Decoded item passed from the front to the back through the queue
  typedef struct packed {
    op_e        op;
    reg_e       addr;
    logic       bad;
    logic [7:0] wdata;
    logic [1:0] mode;
    logic [1:0] color;
    logic       osel;
  } item_t;

  // Pick the two-bit shade of a palette for a colour index
  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
    logic [1:0] shade;
    case (idx)
      2'd0:    shade = pal[1:0];
      2'd1:    shade = pal[3:2];
      2'd2:    shade = pal[5:4];
      default: shade = pal[7:6];
    endcase
    return shade;
  endfunction

endpackage

// ===== rtl/lsr_front.sv =====
// ----------------------------------------------------------------------------
// LCD status register block front decoder
// Unpacks an incoming item, checks its register offset and applies the
// object palette write mask to object palette items before the item is queued.
// ----------------------------------------------------------------------------
module lsr_front (
  input  logic [lsr_pkg::InDataW-1:0] tdata_i,
  input  logic [lsr_pkg::InUserW-1:0] tuser_i,
  output lsr_pkg::item_t              item_o
);

  logic [3:0]   offset;
  logic [7:0]   wdata;
  lsr_pkg::op_e op;
  lsr_pkg::reg_e addr;
  logic         known;
  logic [7:0]   wdata_masked;

  // Unpack the payload fields
  assign offset = tdata_i[3:0];
  assign wdata  = tdata_i[11:4];
  assign op     = lsr_pkg::op_e'(tuser_i);

  // Map the offset onto a register and flag holes in the map
  always_comb begin
    addr  = lsr_pkg::RegControl;
    known = 1'b1;
    unique case (offset)
      4'd0:    addr = lsr_pkg::RegControl;
      4'd1:    addr = lsr_pkg::RegStatus;
      4'd2:    addr = lsr_pkg::RegScrollY;
      4'd3:    addr = lsr_pkg::RegScrollX;
      4'd4:    addr = lsr_pkg::RegLine;
      4'd5:    addr = lsr_pkg::RegCompare;
      4'd7:    addr = lsr_pkg::RegBgPal;
      4'd8:    addr = lsr_pkg::RegObjPal0;
      4'd9:    addr = lsr_pkg::RegObjPal1;
      4'd10:   addr = lsr_pkg::RegWindowY;
      4'd11:   addr = lsr_pkg::RegWindowX;
      default: known = 1'b0;
    endcase
  end

  // Drop the low bits of object palette writes up front
  always_comb begin
    wdata_masked = wdata;
    case (addr)
      lsr_pkg::RegObjPal0,
      lsr_pkg::RegObjPal1: wdata_masked = wdata & lsr_pkg::ObjPalWriteMask;
      default:             wdata_masked = wdata;
    endcase
  end

  // Build the decoded item
  always_comb begin
    item_o.op    = op;
    item_o.addr  = addr;
    item_o.bad   = !known && (op == lsr_pkg::OpRead || op == lsr_pkg::OpWrite);
    item_o.wdata = wdata_masked;
    item_o.mode  = tdata_i[13:12];
    item_o.color = tdata_i[15:14];
    item_o.osel  = tdata_i[16];
  end

endmodule

// ===== rtl/lsr_queue.sv =====
// ----------------------------------------------------------------------------
// LCD status register block item queue
// Two-entry queue of decoded items between the front decoder and the
// register back end, so a stalled back end blocks the front only once full.
// ----------------------------------------------------------------------------
module lsr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsr_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lsr_pkg::item_t pop_item_o
);

  lsr_pkg::item_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/lsr_back.sv =====
// ----------------------------------------------------------------------------
// LCD status register block back end
// Holds the controller registers, carries out one queued item per cycle while
// the result register is free and registers its result for the output stream.
// ----------------------------------------------------------------------------
module lsr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  lsr_pkg::item_t               item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lsr_pkg::OutDataW-1:0] out_data_o
);

  logic [7:0] control_q, control_d;
  logic [6:0] status_q, status_d;
  logic [7:0] scroll_y_q, scroll_y_d;
  logic [7:0] scroll_x_q, scroll_x_d;
  logic [7:0] line_q, line_d;
  logic [7:0] compare_q, compare_d;
  logic [7:0] bg_pal_q, bg_pal_d;
  logic [7:0] obj_pal0_q, obj_pal0_d;
  logic [7:0] obj_pal1_q, obj_pal1_d;
  logic [7:0] window_y_q, window_y_d;
  logic [7:0] window_x_q, window_x_d;

  logic                         out_valid_q, out_valid_d;
  logic [lsr_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic       fire;
  logic [7:0] rd_data;
  logic       irq;
  logic [7:0] line_inc;
  logic       match;
  logic [7:0] obj_pal;
  logic [4:0] obj_height;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign line_inc     = line_q + 8'd1;
  assign match        = (line_inc == compare_q);

  // Read mux over the current registers
  always_comb begin
    rd_data = 8'd0;
    if (item_i.op == lsr_pkg::OpRead && !item_i.bad) begin
      unique case (item_i.addr)
        lsr_pkg::RegControl: rd_data = control_q;
        lsr_pkg::RegStatus:  rd_data = {1'b0, status_q};
        lsr_pkg::RegScrollY: rd_data = scroll_y_q;
        lsr_pkg::RegScrollX: rd_data = scroll_x_q;
        lsr_pkg::RegLine:    rd_data = line_q;
        lsr_pkg::RegCompare: rd_data = compare_q;
        lsr_pkg::RegBgPal:   rd_data = bg_pal_q;
        lsr_pkg::RegObjPal0: rd_data = obj_pal0_q;
        lsr_pkg::RegObjPal1: rd_data = obj_pal1_q;
        lsr_pkg::RegWindowY: rd_data = window_y_q;
        lsr_pkg::RegWindowX: rd_data = window_x_q;
        default:             rd_data = 8'd0;
      endcase
    end
  end

  // Apply the item to the register file
  always_comb begin
    control_d  = control_q;
    status_d   = status_q;
    scroll_y_d = scroll_y_q;
    scroll_x_d = scroll_x_q;
    line_d     = line_q;
    compare_d  = compare_q;
    bg_pal_d   = bg_pal_q;
    obj_pal0_d = obj_pal0_q;
    obj_pal1_d = obj_pal1_q;
    window_y_d = window_y_q;
    window_x_d = window_x_q;
    irq        = 1'b0;
    unique case (item_i.op)
      lsr_pkg::OpRead: begin
        irq = 1'b0;
      end
      lsr_pkg::OpWrite: begin
        if (!item_i.bad) begin
          unique case (item_i.addr)
            lsr_pkg::RegControl: control_d  = item_i.wdata;
            lsr_pkg::RegStatus:  status_d   = (status_q & lsr_pkg::StatusKeepMask)
                                            | (item_i.wdata[6:0] & lsr_pkg::StatusWriteMask);
            lsr_pkg::RegScrollY: scroll_y_d = item_i.wdata;
            lsr_pkg::RegScrollX: scroll_x_d = item_i.wdata;
            lsr_pkg::RegLine:    line_d     = line_q;
            lsr_pkg::RegCompare: compare_d  = item_i.wdata;
            lsr_pkg::RegBgPal:   bg_pal_d   = item_i.wdata;
            lsr_pkg::RegObjPal0: obj_pal0_d = item_i.wdata;
            lsr_pkg::RegObjPal1: obj_pal1_d = item_i.wdata;
            lsr_pkg::RegWindowY: window_y_d = item_i.wdata;
            lsr_pkg::RegWindowX: window_x_d = item_i.wdata;
            default:             control_d  = control_q;
          endcase
        end
      end
      lsr_pkg::OpAdvance: begin
        // Compare the incremented line first, wrap at the frame end after
        if (match) begin
          status_d = status_q | lsr_pkg::CoincSetMask;
          irq      = |(status_d & lsr_pkg::LineIrqEnableMask);
        end else begin
          status_d = status_q & lsr_pkg::CoincClearMask;
        end
        line_d = (line_inc >= lsr_pkg::LinesPerFrame) ? 8'd0 : line_inc;
      end
      lsr_pkg::OpMode: begin
        status_d = (status_q & lsr_pkg::ModeClearMask) | {5'd0, item_i.mode};
      end
      default: begin
        irq = 1'b0;
      end
    endcase
  end

  // Build the result from the post-item state
  assign obj_pal    = item_i.osel ? obj_pal1_d : obj_pal0_d;
  assign obj_height = control_d[2] ? lsr_pkg::ObjHeightTall : lsr_pkg::ObjHeightShort;

  always_comb begin
    out_data_d = {6'd0,
                  status_d,
                  obj_height,
                  control_d,
                  lsr_pkg::shade_of(obj_pal, item_i.color),
                  lsr_pkg::shade_of(bg_pal_d, item_i.color),
                  line_d,
                  irq,
                  item_i.bad,
                  rd_data};
    out_valid_d = fire || (out_valid_q && !out_ready_i);
  end

  // Commit registers on an executed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q  <= lsr_pkg::ControlReset;
      status_q   <= 7'd0;
      scroll_y_q <= 8'd0;
      scroll_x_q <= 8'd0;
      line_q     <= 8'd0;
      compare_q  <= 8'd0;
      bg_pal_q   <= lsr_pkg::BgPalReset;
      obj_pal0_q <= lsr_pkg::ObjPalReset;
      obj_pal1_q <= lsr_pkg::ObjPalReset;
      window_y_q <= 8'd0;
      window_x_q <= 8'd0;
    end else if (fire) begin
      control_q  <= control_d;
      status_q   <= status_d;
      scroll_y_q <= scroll_y_d;
      scroll_x_q <= scroll_x_d;
      line_q     <= line_d;
      compare_q  <= compare_d;
      bg_pal_q   <= bg_pal_d;
      obj_pal0_q <= obj_pal0_d;
      obj_pal1_q <= obj_pal1_d;
      window_y_q <= window_y_d;
      window_x_q <= window_x_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/lcd_status_register_block.sv =====
// ----------------------------------------------------------------------------
// LCD status register block
// Register file of a handheld console's LCD controller with bus access,
// line counting with compare interrupt and palette shade lookups.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command per item: the command code in
//   tuser and its operands in tdata. The master stream returns exactly one
//   result item per command, in order, holding the read data, the address
//   error and line interrupt flags, the line counter, both palette shades,
//   the control word, the object height and the status word.
//   An accepted item is decoded and written into the queue; the register
//   back end executes it once its result register is free and registers
//   the result for the master side. Unless the receiver stalls, the back end
//   executes one item per cycle, so the block sustains one item per clock.
//   A two-entry queue sits between decoder and back end, and a result
//   register sits on the master side. When the receiver stalls, the result
//   holds, the queue fills, and s_axis_tready_o drops once both queue
//   entries are taken; it rises again after a result is accepted.
//   Reset empties the queue and the result register and loads the register
//   reset values (control 0x91, palettes 0xFC/0xFF/0xFF, all others zero).
// ----------------------------------------------------------------------------
module lcd_status_register_block (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: reg_offset[3:0], write_data[11:4], mode_value[13:12],
  //        color_index[15:14], obj_palette_select[16], zero[23:17]
  input  logic [lsr_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [lsr_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata: read_data[7:0], bad_address[8], line_irq[9], current_line[17:10],
  //        bg_shade[19:18], obj_shade[21:20], control_word[29:22],
  //        obj_height[34:30], status_word[41:35], zero[47:42]
  output logic [lsr_pkg::OutDataW-1:0] m_axis_tdata_o
);

  lsr_pkg::item_t dec_item;
  lsr_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  // Decode incoming items
  lsr_front u_front (
    .tdata_i (s_axis_tdata_i),
    .tuser_i (s_axis_tuser_i),
    .item_o  (dec_item)
  );

  // Buffer decoded items
  lsr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_item_i  (dec_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Execute items against the register file
  lsr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// LCD status register block testbench
// Streams bus reads and writes, line advances and mode sets into the block
// with random gaps on both sides, predicts each result from a local copy of
// the register file and checks every result field in order of arrival.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 1450;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxReports   = 10;
  localparam logic [7:0]  FrameLines   = 8'd154;

  // One command as the sender sees it
  typedef struct {
    lsr_pkg::op_e op;
    logic [3:0]   off;
    logic [7:0]   wdata;
    logic [1:0]   mode;
    logic [1:0]   color;
    logic         osel;
  } lcd_cmd_t;

  // One result with every field unpacked
  typedef struct {
    logic [7:0] rdata;
    logic       bad;
    logic       irq;
    logic [7:0] line;
    logic [1:0] bg;
    logic [1:0] obj;
    logic [7:0] ctrl;
    logic [4:0] height;
    logic [6:0] status;
  } lcd_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [lsr_pkg::InDataW-1:0]  s_tdata = '0;
  logic [lsr_pkg::InUserW-1:0]  s_tuser = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [lsr_pkg::OutDataW-1:0] m_tdata;

  lcd_status_register_block u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted register file
  logic [7:0] mdl_control, mdl_scroll_y, mdl_scroll_x, mdl_line, mdl_compare;
  logic [7:0] mdl_bg_pal, mdl_obj_pal0, mdl_obj_pal1, mdl_window_y, mdl_window_x;
  logic [6:0] mdl_status;

  lcd_cmd_t    cmd_pending[$];
  lcd_result_t exp_results[$];
  lcd_cmd_t    drv_cmd;
  int unsigned items_total;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned drv_gap = 0, drv_calm = 0;
  int unsigned rx_hold = 0, rx_calm = 0;
  logic [7:0]  gen_line;

  function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] idx);
    logic [7:0] shifted;
    shifted = pal >> (2 * idx);
    return shifted[1:0];
  endfunction

  // Apply one command to the predicted registers and build its result
  function automatic lcd_result_t lcd_regs_apply(input lcd_cmd_t c);
    lcd_result_t r;
    logic [7:0]  opal;
    r = '{default: '0};
    case (c.op)
      lsr_pkg::OpRead: begin
        case (c.off)
          lsr_pkg::RegControl: r.rdata = mdl_control;
          lsr_pkg::RegStatus:  r.rdata = {1'b0, mdl_status};
          lsr_pkg::RegScrollY: r.rdata = mdl_scroll_y;
          lsr_pkg::RegScrollX: r.rdata = mdl_scroll_x;
          lsr_pkg::RegLine:    r.rdata = mdl_line;
          lsr_pkg::RegCompare: r.rdata = mdl_compare;
          lsr_pkg::RegBgPal:   r.rdata = mdl_bg_pal;
          lsr_pkg::RegObjPal0: r.rdata = mdl_obj_pal0;
          lsr_pkg::RegObjPal1: r.rdata = mdl_obj_pal1;
          lsr_pkg::RegWindowY: r.rdata = mdl_window_y;
          lsr_pkg::RegWindowX: r.rdata = mdl_window_x;
          default:             r.bad = 1'b1;
        endcase
      end
      lsr_pkg::OpWrite: begin
        case (c.off)
          lsr_pkg::RegControl: mdl_control = c.wdata;
          // keep mode and coincidence bits, take the interrupt enables
          lsr_pkg::RegStatus:  mdl_status = (mdl_status & 7'h07) | (c.wdata[6:0] & 7'h78);
          lsr_pkg::RegScrollY: mdl_scroll_y = c.wdata;
          lsr_pkg::RegScrollX: mdl_scroll_x = c.wdata;
          lsr_pkg::RegLine:    ;
          lsr_pkg::RegCompare: mdl_compare = c.wdata;
          lsr_pkg::RegBgPal:   mdl_bg_pal = c.wdata;
          lsr_pkg::RegObjPal0: mdl_obj_pal0 = c.wdata & 8'hFC;
          lsr_pkg::RegObjPal1: mdl_obj_pal1 = c.wdata & 8'hFC;
          lsr_pkg::RegWindowY: mdl_window_y = c.wdata;
          lsr_pkg::RegWindowX: mdl_window_x = c.wdata;
          default:             r.bad = 1'b1;
        endcase
      end
      lsr_pkg::OpAdvance: begin
        // compare before the wrap at the frame line count
        mdl_line = mdl_line + 8'd1;
        if (mdl_line == mdl_compare) begin
          mdl_status[2] = 1'b1;
          r.irq = mdl_status[6];
        end else begin
          mdl_status[2] = 1'b0;
        end
        if (mdl_line >= FrameLines) mdl_line = 8'd0;
      end
      default: mdl_status[1:0] = c.mode;
    endcase
    opal = c.osel ? mdl_obj_pal1 : mdl_obj_pal0;
    r.line   = mdl_line;
    r.bg     = pal_shade(mdl_bg_pal, c.color);
    r.obj    = pal_shade(opal, c.color);
    r.ctrl   = mdl_control;
    r.height = mdl_control[2] ? 5'd16 : 5'd8;
    r.status = mdl_status;
    return r;
  endfunction

  // Queue one command with random mode and palette lookup fields
  task automatic push_cmd(input lsr_pkg::op_e op, input logic [3:0] off,
                          input logic [7:0] wdata);
    lcd_cmd_t c;
    c.op    = op;
    c.off   = off;
    c.wdata = wdata;
    c.mode  = 2'($urandom_range(0, 3));
    c.color = 2'($urandom_range(0, 3));
    c.osel  = 1'($urandom_range(0, 1));
    cmd_pending.push_back(c);
    if (op == lsr_pkg::OpAdvance) begin
      gen_line = gen_line + 8'd1;
      if (gen_line >= FrameLines) gen_line = 8'd0;
    end
  endtask

  // Pick an idle length: mostly none, some short, a few long, with calm stretches
  task automatic pick_gap(inout int unsigned calm, output int unsigned gap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm != 0) begin
      calm--;
      gap = 0;
    end else if (r < 3) begin
      calm = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 65) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(6, 20);
    end
  endtask

  // Drive commands, predict each one at its handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        exp_results.push_back(lcd_regs_apply(drv_cmd));
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (drv_gap != 0) begin
          drv_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_pending.size() != 0) begin
          drv_cmd = cmd_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, drv_cmd.osel, drv_cmd.color, drv_cmd.mode,
                       drv_cmd.wdata, drv_cmd.off};
          s_tuser  <= drv_cmd.op;
          pick_gap(drv_calm, drv_gap);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // Accept results with random stalls and compare against the oldest prediction
  lcd_result_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (exp_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) $display("result with no command pending");
        end else begin
          exp_r = exp_results.pop_front();
          check_field("read_data", exp_r.rdata, m_tdata[7:0]);
          check_field("bad_address", 8'(exp_r.bad), 8'(m_tdata[8]));
          check_field("line_irq", 8'(exp_r.irq), 8'(m_tdata[9]));
          check_field("current_line", exp_r.line, m_tdata[17:10]);
          check_field("bg_shade", 8'(exp_r.bg), 8'(m_tdata[19:18]));
          check_field("obj_shade", 8'(exp_r.obj), 8'(m_tdata[21:20]));
          check_field("control_word", exp_r.ctrl, m_tdata[29:22]);
          check_field("obj_height", 8'(exp_r.height), 8'(m_tdata[34:30]));
          check_field("status_word", 8'(exp_r.status), 8'(m_tdata[41:35]));
        end
      end
      if (rx_hold != 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        pick_gap(rx_calm, rx_hold);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Build the stimulus, release reset and wait for the drain
  initial begin
    int unsigned k, n, sel;
    logic [7:0]  at_match, walk;
    mdl_control  = 8'h91;
    mdl_status   = 7'd0;
    mdl_scroll_y = 8'd0;
    mdl_scroll_x = 8'd0;
    mdl_line     = 8'd0;
    mdl_compare  = 8'd0;
    mdl_bg_pal   = 8'hFC;
    mdl_obj_pal0 = 8'hFF;
    mdl_obj_pal1 = 8'hFF;
    mdl_window_y = 8'd0;
    mdl_window_x = 8'd0;
    gen_line     = 8'd0;

    // reset values and every offset, unsupported ones included
    for (int i = 0; i < 16; i++) push_cmd(lsr_pkg::OpRead, 4'(i), 8'hFF);
    // status keeps its low bits, line counter ignores writes, object palettes drop bits
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegStatus, 8'hFF);
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegLine, 8'hFF);
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegObjPal0, 8'hFF);
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegObjPal1, 8'h03);
    push_cmd(lsr_pkg::OpWrite, 4'd6, 8'hFF);
    push_cmd(lsr_pkg::OpWrite, 4'd15, 8'h00);
    // compare match with the interrupt enabled, then a mismatch
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegCompare, 8'd1);
    push_cmd(lsr_pkg::OpAdvance, lsr_pkg::RegControl, 8'h00);
    push_cmd(lsr_pkg::OpAdvance, lsr_pkg::RegControl, 8'h00);
    push_cmd(lsr_pkg::OpMode, lsr_pkg::RegControl, 8'h00);
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegControl, 8'h04);
    push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegBgPal, 8'h1B);

    // random scenarios: compare-and-advance runs, single writes, reads and mode sets
    while (cmd_pending.size() < 25 + RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        // long run of advances, half the time with the compare at the frame line count
        push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegCompare,
                 $urandom_range(0, 1) ? FrameLines : 8'($urandom_range(0, 255)));
        n = $urandom_range(20, 160);
        for (int i = 0; i < n; i++) push_cmd(lsr_pkg::OpAdvance, 4'($urandom_range(0, 15)),
                                              8'($urandom_range(0, 255)));
      end else if (sel < 45) begin
        // aim the compare a few lines ahead and advance up to or past it
        k = $urandom_range(1, 6);
        walk = gen_line;
        at_match = walk;
        for (int i = 0; i < k; i++) begin
          walk = walk + 8'd1;
          at_match = walk;
          if (walk >= FrameLines) walk = 8'd0;
        end
        push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegCompare, at_match);
        if ($urandom_range(0, 1))
          push_cmd(lsr_pkg::OpWrite, lsr_pkg::RegStatus, 8'($urandom_range(0, 255)));
        n = k + $urandom_range(0, 2);
        for (int i = 0; i < n; i++) push_cmd(lsr_pkg::OpAdvance, 4'($urandom_range(0, 15)),
                                              8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
          push_cmd(lsr_pkg::OpRead, lsr_pkg::RegStatus, 8'($urandom_range(0, 255)));
      end else if (sel < 70) begin
        push_cmd(lsr_pkg::OpWrite, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else if (sel < 90) begin
        push_cmd(lsr_pkg::OpRead, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else begin
        push_cmd(lsr_pkg::OpMode, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end
    end
    items_total = cmd_pending.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted != items_total) @(posedge clk_i);
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && exp_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lsr_pkg.sv
rtl/lsr_front.sv
rtl/lsr_queue.sv
rtl/lsr_back.sv
rtl/lcd_status_register_block.sv
tb/tb.sv
